// File: rtl/assert_macros.svh
// Assertion macros shared by the sanitizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/u8san_pkg.sv
// Types and constants of the UTF-8 stream sanitizer.
`default_nettype none

package u8san_pkg;

    localparam logic [7:0] QMARK     = 8'h3F;
    localparam logic [7:0] CTRL_MAX  = 8'h1F;
    localparam logic [7:0] CONT_LO   = 8'h80;
    localparam logic [7:0] LEAD2_LO  = 8'hC0;
    localparam logic [7:0] LEAD3_LO  = 8'hE0;
    localparam logic [7:0] LEAD4_LO  = 8'hF0;
    localparam logic [7:0] LEAD4_HI  = 8'hF7;
    localparam logic [1:0] CONT_TAG  = 2'b10;

    localparam int HELD_N  = 3;
    localparam int RES_MAX = HELD_N + 1;
    localparam int Q_AW    = 2;
    localparam int Q_DEPTH = 1 << Q_AW;

    // One queue entry: all results caused by one input beat.
    typedef struct packed {
        logic [RES_MAX-1:0][7:0] bytes;
        logic [2:0]              cnt;
        logic                    present;
        logic                    mend;
        logic                    mvalid;
    } t_entry;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

`default_nettype wire

// File: rtl/u8san_front.sv
// Front end: classifies input bytes, tracks pending sequences, builds result entries.
`default_nettype none

`include "assert_macros.svh"

module u8san_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [7:0]          i_in_byte,
    input  wire logic                i_in_last,
    input  wire u8san_pkg::t_q_stat  i_stat,
    output logic                     o_push,
    output u8san_pkg::t_entry        o_entry
);

    logic [1:0] r_expect, n_expect;
    logic [1:0] r_hcount, n_hcount;
    logic       r_err, n_err;
    logic [u8san_pkg::HELD_N-1:0][7:0] r_held, n_held;

    logic       accept;
    logic [1:0] need;
    logic [1:0] hidx;
    logic       err_now;
    logic       err_end;

    function automatic logic [1:0] lead_need(input logic [7:0] b);
        logic [1:0] r;
        r = 2'd0;
        if (b >= u8san_pkg::LEAD2_LO && b < u8san_pkg::LEAD3_LO) r = 2'd1;
        else if (b >= u8san_pkg::LEAD3_LO && b < u8san_pkg::LEAD4_LO) r = 2'd2;
        else if (b >= u8san_pkg::LEAD4_LO && b <= u8san_pkg::LEAD4_HI) r = 2'd3;
        return r;
    endfunction

    assign o_ready = !i_stat.full;
    assign accept  = i_valid && o_ready;
    assign need    = lead_need(i_in_byte);
    assign hidx    = (r_hcount == 2'd0) ? 2'd0 : ((r_hcount == 2'd3) ? 2'd2 : r_hcount);

    always_comb begin
        n_expect = r_expect;
        n_hcount = r_hcount;
        n_held   = r_held;
        err_now  = r_err;
        err_end  = 1'b0;
        o_entry.bytes   = {u8san_pkg::RES_MAX{u8san_pkg::QMARK}};
        o_entry.cnt     = 3'd0;
        o_entry.present = 1'b1;
        o_entry.mend    = 1'b0;
        o_entry.mvalid  = 1'b0;
        if (r_expect == 2'd0) begin
            if (need != 2'd0) begin
                n_held[0] = i_in_byte;
                n_hcount  = 2'd1;
                n_expect  = need;
            end else begin
                o_entry.cnt = 3'd1;
                if (i_in_byte >= u8san_pkg::CONT_LO) begin
                    err_now = 1'b1;
                end else if (i_in_byte > u8san_pkg::CTRL_MAX) begin
                    o_entry.bytes[0] = i_in_byte;
                end
            end
        end else if (i_in_byte[7:6] == u8san_pkg::CONT_TAG) begin
            if (r_expect == 2'd1) begin
                for (int k = 0; k < u8san_pkg::HELD_N; k++) begin
                    if (2'(k) < r_hcount) o_entry.bytes[k] = r_held[k];
                end
                o_entry.bytes[r_hcount] = i_in_byte;
                o_entry.cnt = {1'b0, r_hcount} + 3'd1;
                n_hcount = 2'd0;
                n_expect = 2'd0;
            end else begin
                n_held[hidx] = i_in_byte;
                if (r_hcount != 2'd3) n_hcount = r_hcount + 2'd1;
                n_expect = r_expect - 2'd1;
            end
        end else begin
            o_entry.cnt = {1'b0, r_hcount} + 3'd1;
            n_hcount = 2'd0;
            n_expect = 2'd0;
            err_now  = 1'b1;
        end
        n_err = err_now;
        if (i_in_last) begin
            err_end = err_now || (n_expect != 2'd0);
            if (o_entry.cnt == 3'd0) begin
                o_entry.cnt      = 3'd1;
                o_entry.bytes[0] = 8'h00;
                o_entry.present  = 1'b0;
            end
            o_entry.mend   = 1'b1;
            o_entry.mvalid = !err_end;
            n_expect = 2'd0;
            n_hcount = 2'd0;
            n_err    = 1'b0;
        end
    end

    assign o_push = accept && (o_entry.cnt != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect <= 2'd0;
            r_hcount <= 2'd0;
            r_err    <= 1'b0;
        end else if (accept) begin
            r_expect <= n_expect;
            r_hcount <= n_hcount;
            r_err    <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held <= n_held;
        end
    end

    `ASSERT_IMP(a_pend_held, i_clk, i_rst_n, r_expect != 2'd0, r_hcount != 2'd0)
    `ASSERT_IMP(a_idle_empty, i_clk, i_rst_n, r_expect == 2'd0, r_hcount == 2'd0)
    `ASSERT_NXT(a_last_clears, i_clk, i_rst_n, accept && i_in_last,
        r_expect == 2'd0 && r_hcount == 2'd0 && !r_err)

endmodule

`default_nettype wire

// File: rtl/u8san_queue.sv
// Short entry queue between the front end and the output sequencer.
`default_nettype none

`include "assert_macros.svh"

module u8san_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire u8san_pkg::t_entry  i_entry,
    input  wire logic               i_pop,
    output u8san_pkg::t_entry       o_head,
    output u8san_pkg::t_q_stat      o_stat
);

    u8san_pkg::t_entry r_mem [u8san_pkg::Q_DEPTH];
    logic [u8san_pkg::Q_AW-1:0] r_wr, r_rd;
    logic [u8san_pkg::Q_AW:0]   r_count;

    assign o_head = r_mem[r_rd];
    assign o_stat = '{
        empty: (r_count == '0),
        full:  (r_count == (u8san_pkg::Q_AW+1)'(u8san_pkg::Q_DEPTH))
    };

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + (u8san_pkg::Q_AW)'(1);
            if (i_pop)  r_rd <= r_rd + (u8san_pkg::Q_AW)'(1);
            if (i_push && !i_pop) r_count <= r_count + (u8san_pkg::Q_AW+1)'(1);
            else if (!i_push && i_pop) r_count <= r_count - (u8san_pkg::Q_AW+1)'(1);
        end
    end

    `ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, !o_stat.full)
    `ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_pop, !o_stat.empty)
    `ASSERT_IMP(a_entry_nonempty, i_clk, i_rst_n, !o_stat.empty,
        o_head.cnt != 3'd0 && o_head.cnt <= 3'(u8san_pkg::RES_MAX))

endmodule

`default_nettype wire

// File: rtl/u8san_back.sv
// Back end: walks each queued entry one result beat at a time into the output register.
`default_nettype none

`include "assert_macros.svh"

module u8san_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire u8san_pkg::t_entry  i_head,
    input  wire u8san_pkg::t_q_stat i_stat,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [7:0]              o_out_byte,
    output logic                    o_byte_present,
    output logic                    o_run_last,
    output logic                    o_message_end,
    output logic                    o_message_valid
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_present, r_run_last, r_mend, r_mvalid;
    logic       take;
    logic       at_end;

    assign take   = (!r_valid || i_ready) && !i_stat.empty;
    assign at_end = ({1'b0, r_idx} == (i_head.cnt - 3'd1));
    assign o_pop  = take && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (take) begin
                r_valid <= 1'b1;
                r_idx   <= at_end ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte     <= i_head.bytes[r_idx];
            r_present  <= i_head.present;
            r_run_last <= at_end;
            r_mend     <= at_end && i_head.mend;
            r_mvalid   <= at_end && i_head.mend && i_head.mvalid;
        end
    end

    assign o_valid         = r_valid;
    assign o_out_byte      = r_byte;
    assign o_byte_present  = r_present;
    assign o_run_last      = r_run_last;
    assign o_message_end   = r_mend;
    assign o_message_valid = r_mvalid;

    `ASSERT_IMP(a_idx_in_entry, i_clk, i_rst_n, !i_stat.empty, {1'b0, r_idx} < i_head.cnt)
    `ASSERT_IMP(a_end_on_run_last, i_clk, i_rst_n, r_valid && r_mend, r_run_last)

endmodule

`default_nettype wire

// File: rtl/utf8_stream_sanitizer.sv
// Top level of the UTF-8 stream sanitizer.
// Accepts one message byte per cycle unless the queue is full, and writes a cleaned
// copy: complete UTF-8 sequences pass unchanged once their last continuation byte
// arrives, while control bytes, stray or invalid bytes and broken sequences come
// out as '?'. The final beat of each message carries message_end and the validity
// verdict; an unfinished sequence at message end yields a bare end marker. The
// front end takes one input beat per cycle while the queue is not full; each beat's
// results (up to four) are queued in a four-entry queue and drained by the back
// end at one output beat per cycle while the receiver is ready, so the sustained
// rate is one byte per cycle and a burst of four results from one beat is absorbed
// by the queue. A beat passes through a queue entry, then the output register.
`default_nettype none

module utf8_stream_sanitizer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_in_last,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_byte_present,
    output logic            o_run_last,
    output logic            o_message_end,
    output logic            o_message_valid
);

    u8san_pkg::t_entry  push_entry;
    u8san_pkg::t_entry  head;
    u8san_pkg::t_q_stat stat;
    logic               push;
    logic               pop;

    u8san_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_in_byte (i_in_byte),
        .i_in_last (i_in_last),
        .i_stat    (stat),
        .o_push    (push),
        .o_entry   (push_entry)
    );

    u8san_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (stat)
    );

    u8san_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_stat          (stat),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_byte      (o_out_byte),
        .o_byte_present  (o_byte_present),
        .o_run_last      (o_run_last),
        .o_message_end   (o_message_end),
        .o_message_valid (o_message_valid)
    );

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the UTF-8 stream sanitizer: random bursty traffic and a predictor.
`default_nettype none

module tb_top;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       run_last;
        logic       msg_end;
        logic       msg_ok;
    } t_san_out;

    typedef struct {
        logic [7:0] b;
        logic       last;
        bit         hold;
    } t_raw_item;

    localparam int WDOG_LIMIT = 3000;
    localparam int STALL_LEN  = 300;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_in_last = 1'b0;
    logic       i_ready = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_byte_present;
    logic       o_run_last;
    logic       o_message_end;
    logic       o_message_valid;

    utf8_stream_sanitizer u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_in_byte       (i_in_byte),
        .i_in_last       (i_in_last),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_byte      (o_out_byte),
        .o_byte_present  (o_byte_present),
        .o_run_last      (o_run_last),
        .o_message_end   (o_message_end),
        .o_message_valid (o_message_valid)
    );

    always #4 i_clk = ~i_clk;

    t_raw_item  raw_q[$];
    t_san_out   sanitized_q[$];

    // predictor state
    logic [1:0] cont_needed = '0;
    logic [7:0] seq_bytes[3];
    logic [1:0] seq_len = '0;
    logic       bad_seen = 1'b0;

    int n_items = 0;
    int in_beats = 0;
    int out_beats = 0;
    int n_bad = 0;
    int n_msg_ok = 0;
    int n_msg_bad = 0;
    int n_bare = 0;
    int n_drains = 0;
    int n_stalls = 0;
    bit tail_phase = 1'b0;

    task automatic sanitize_beat(input logic [7:0] b, input logic last);
        t_san_out r[4];
        int       n;
        logic     err;
        n = 0;
        err = bad_seen;
        for (int j = 0; j < 4; j++) r[j] = '0;
        if (cont_needed == 2'd0) begin
            if (b >= u8san_pkg::LEAD2_LO && b <= u8san_pkg::LEAD4_HI) begin
                seq_bytes[0] = b;
                seq_len = 2'd1;
                cont_needed = (b >= u8san_pkg::LEAD4_LO) ? 2'd3 :
                              (b >= u8san_pkg::LEAD3_LO) ? 2'd2 : 2'd1;
            end else if (b >= u8san_pkg::CONT_LO) begin
                r[n].data = u8san_pkg::QMARK; r[n].present = 1'b1; n++;
                err = 1'b1;
            end else if (b <= u8san_pkg::CTRL_MAX) begin
                r[n].data = u8san_pkg::QMARK; r[n].present = 1'b1; n++;
            end else begin
                r[n].data = b; r[n].present = 1'b1; n++;
            end
        end else if (b[7:6] == u8san_pkg::CONT_TAG) begin
            if (cont_needed == 2'd1) begin
                for (int j = 0; j < seq_len; j++) begin
                    r[n].data = seq_bytes[j]; r[n].present = 1'b1; n++;
                end
                r[n].data = b; r[n].present = 1'b1; n++;
                seq_len = 2'd0;
                cont_needed = 2'd0;
            end else begin
                seq_bytes[seq_len] = b;
                seq_len = seq_len + 2'd1;
                cont_needed = cont_needed - 2'd1;
            end
        end else begin
            for (int j = 0; j < seq_len; j++) begin
                r[n].data = u8san_pkg::QMARK; r[n].present = 1'b1; n++;
            end
            r[n].data = u8san_pkg::QMARK; r[n].present = 1'b1; n++;
            seq_len = 2'd0;
            cont_needed = 2'd0;
            err = 1'b1;
        end
        bad_seen = err;
        if (last) begin
            if (cont_needed != 2'd0) err = 1'b1;
            if (n == 0) begin
                r[0] = '0; n = 1;
            end
            r[n-1].msg_end = 1'b1;
            r[n-1].msg_ok = ~err;
            cont_needed = 2'd0;
            seq_len = 2'd0;
            bad_seen = 1'b0;
        end
        if (n > 0) r[n-1].run_last = 1'b1;
        for (int j = 0; j < n; j++) sanitized_q.push_back(r[j]);
    endtask

    int gap_left = 0;
    int burst_left = 1;

    // driver
    always @(posedge i_clk) begin : drv_p
        t_raw_item it;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                sanitize_beat(i_in_byte, i_in_last);
                in_beats++;
            end
            if (i_valid && !o_ready) begin
                // hold current beat
            end else if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 1'b0;
            end else if (raw_q.size() != 0 && raw_q[0].hold) begin
                i_valid <= 1'b0;
                if (sanitized_q.size() == 0) begin
                    void'(raw_q.pop_front());
                    n_drains++;
                end
            end else if (raw_q.size() != 0) begin
                it = raw_q.pop_front();
                i_in_byte <= it.b;
                i_in_last <= it.last;
                i_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver
    int       stall_left = 0;
    int       next_stall_at = 120;
    int       cyc = 0;
    int       rx_mode = 0;

    task automatic report_bad(input string what, input t_san_out want, input t_san_out got);
        n_bad++;
        if (n_bad <= 10) begin
            $display("mismatch (%s) at beat %0d", what, out_beats);
            $display("  exp byte=%02h pres=%b rl=%b end=%b ok=%b",
                     want.data, want.present, want.run_last, want.msg_end, want.msg_ok);
            $display("  got byte=%02h pres=%b rl=%b end=%b ok=%b",
                     got.data, got.present, got.run_last, got.msg_end, got.msg_ok);
        end
    endtask

    always @(posedge i_clk) begin : mon_p
        t_san_out got;
        t_san_out want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            cyc++;
            if (o_valid && i_ready) begin
                out_beats++;
                got = {o_out_byte, o_byte_present, o_run_last, o_message_end, o_message_valid};
                if (got.msg_end) begin
                    if (got.msg_ok) n_msg_ok++; else n_msg_bad++;
                    if (!got.present) n_bare++;
                end
                if (sanitized_q.size() == 0) begin
                    report_bad("unexpected", '0, got);
                end else begin
                    want = sanitized_q.pop_front();
                    if (got !== want) report_bad("field", want, got);
                end
            end
            if (cyc % 64 == 0) rx_mode <= $urandom_range(0, 3);
            if (tail_phase) begin
                i_ready <= 1'b1;
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                i_ready <= 1'b0;
            end else if (out_beats >= next_stall_at) begin
                stall_left <= STALL_LEN;
                next_stall_at <= next_stall_at + 400;
                n_stalls++;
                i_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: i_ready <= 1'b1;
                    1: i_ready <= 1'($urandom_range(0, 1));
                    2: i_ready <= (cyc % 4 != 0);
                    default: i_ready <= (cyc % 8 == 0);
                endcase
            end
        end
    end

    // watchdog
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", WDOG_LIMIT);
                $display("[utf8_stream_sanitizer] ERROR");
                $finish;
            end
        end
    end

    task automatic put_raw(input logic [7:0] b, input logic last);
        t_raw_item it;
        it.b = b;
        it.last = last;
        it.hold = 1'b0;
        raw_q.push_back(it);
        n_items++;
    endtask

    task automatic put_drain();
        t_raw_item it;
        it.b = 8'h00;
        it.last = 1'b0;
        it.hold = 1'b1;
        raw_q.push_back(it);
    endtask

    function automatic logic [7:0] cont_byte();
        logic [5:0] v;
        v = 6'($urandom);
        return {u8san_pkg::CONT_TAG, v};
    endfunction

    function automatic logic [7:0] lead_byte(input int need);
        logic [4:0] v;
        v = 5'($urandom);
        case (need)
            1: return {3'b110, v};
            2: return {4'b1110, v[3:0]};
            default: return {5'b11110, v[2:0]};
        endcase
    endfunction

    task automatic add_message(input bit noisy);
        logic [7:0] m[$];
        logic [7:0] v;
        int         nchars;
        int         k;
        int         need;
        int         cut;
        nchars = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
        for (int c = 0; c < nchars; c++) begin
            k = $urandom_range(0, 19);
            if (noisy) begin
                v = 8'($urandom);
                m.push_back(v);
            end else if (k < 8) begin
                v = 8'($urandom_range(8'h20, 8'h7F));
                m.push_back(v);
            end else if (k < 9) begin
                v = 8'($urandom_range(8'h00, 8'h1F));
                m.push_back(v);
            end else if (k < 16) begin
                need = $urandom_range(1, 3);
                m.push_back(lead_byte(need));
                repeat (need) m.push_back(cont_byte());
            end else if (k == 16) begin
                m.push_back(cont_byte());
            end else if (k == 17) begin
                v = 8'($urandom_range(8'hF8, 8'hFF));
                m.push_back(v);
            end else begin
                need = $urandom_range(1, 3);
                cut = $urandom_range(0, need - 1);
                m.push_back(lead_byte(need));
                repeat (cut) m.push_back(cont_byte());
                if (k == 19) break;
                v = 8'($urandom);
                while (v[7:6] == u8san_pkg::CONT_TAG) v = 8'($urandom);
                m.push_back(v);
            end
        end
        foreach (m[j]) put_raw(m[j], j == m.size() - 1);
    endtask

    initial begin
        // plain, control, extremes
        put_raw(8'h20, 0); put_raw(8'h7F, 0); put_raw(8'h00, 0); put_raw(8'h1F, 1);
        // stray continuations and invalid leads
        put_raw(8'h80, 0); put_raw(8'hBF, 0); put_raw(8'hF8, 0); put_raw(8'hFF, 1);
        // complete sequences of every length
        put_raw(8'hC0, 0); put_raw(8'h80, 0);
        put_raw(8'hE0, 0); put_raw(8'hA0, 0); put_raw(8'h80, 0);
        put_raw(8'hF7, 0); put_raw(8'hBF, 0); put_raw(8'hBF, 0); put_raw(8'hBF, 1);
        // broken four-byte sequence, last on the breaker
        put_raw(8'hF0, 0); put_raw(8'h90, 0); put_raw(8'h80, 0); put_raw(8'h41, 1);
        // lead breaks lead, then unfinished sequence at message end
        put_raw(8'hC3, 0); put_raw(8'hC3, 0); put_raw(8'hE2, 0); put_raw(8'h82, 1);
        put_drain();
        while (n_items < 225) add_message($urandom_range(0, 7) == 0);
        put_drain();
        while (n_items < 450) add_message($urandom_range(0, 7) == 0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (in_beats != n_items) @(posedge i_clk);
        while (sanitized_q.size() != 0) @(posedge i_clk);
        tail_phase <= 1'b1;
        repeat (16) @(posedge i_clk);

        $display("covered %0d input beats, %0d result beats, %0d messages (%0d ok, %0d bad)",
                 in_beats, out_beats, n_msg_ok + n_msg_bad, n_msg_ok, n_msg_bad);
        $display("bare end markers %0d, drain pauses %0d, long receiver stalls %0d, mismatches %0d",
                 n_bare, n_drains, n_stalls, n_bad);
        if (n_bad == 0 && sanitized_q.size() == 0) begin
            $display("[utf8_stream_sanitizer] OK");
        end else begin
            $display("[utf8_stream_sanitizer] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
